// ===== rtl/core/int64_to_text_top_assert.svh =====
// Assertion macros shared by the converter RTL.
`ifndef INT64_TO_TEXT_TOP_ASSERT_SVH
`define INT64_TO_TEXT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define I2T_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define I2T_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2t_pkg.sv =====
// Types, constants and helpers shared by the integer-to-text converter.
package i2t_pkg;

	localparam int I2T_VALUE_BITS_DEF = 64;

	// Input tdata layout, lowest bit first.
	localparam int IN_TDATA_W = 72;
	localparam int IN_VALUE_W = 64;
	localparam int IN_RADIX_LSB = 64;
	localparam int IN_RADIX_W = 5;
	localparam int IN_SIGNED_BIT = 69;

	localparam logic [IN_RADIX_W-1:0] RADIX_DEC = 5'd10;
	localparam logic [IN_RADIX_W-1:0] RADIX_HEX = 5'd16;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_NONE = 8'h00;

	typedef enum logic [2:0] {
		DU_HOLD,
		DU_LOAD_DEC,
		DU_LOAD_HEX,
		DU_DABBLE,
		DU_SHIFT
	} du_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_PREFIX,
		ST_DIGIT,
		ST_BAD
	} state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return {4'b0000, d} + CH_ZERO;
		end else begin
			return {4'b0000, d - 4'd10} + CH_LOWER_A;
		end
	endfunction

endpackage

// ===== rtl/core/int64_to_text_top.sv =====
// Top level of the integer-to-text converter: sequencer, prefix logic and output register.
//
// Usage: one transfer on the s_ channel carries a value, a radix and a signed flag.
// The block answers with the ASCII text of the value on the m_ channel, one
// character per transfer, most significant first, with m_tlast on the final one.
// Radix 16 gives "0x" and lowercase digits; radix 10 gives decimal digits, with a
// leading '-' for a negative value when the signed flag is set. Any other radix
// with a nonzero value gives one transfer with m_tuser (invalid) set and data zero.
// Timing: s_tready is high only while the block is idle. A decimal item first runs
// through the shift-and-add-3 loop of the digit unit, then drops leading zero
// digits, then sends one character per cycle while the receiver is ready.
// A hex item skips the conversion loop.
// A stalled receiver holds the output register, and the sequencer waits with it.
// Reset clears the sequencer and the output valid; no item is in flight after it.
`include "int64_to_text_top_assert.svh"

module int64_to_text_top
	import i2t_pkg::*;
#(
	parameter int VALUE_BITS = I2T_VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // value[63:0], radix[68:64], is_signed[69], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // character[7:0]
	output logic                  m_tlast,
	output logic                  m_tuser    // invalid
);

	localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DCW = $clog2(NDIG + 1);
	localparam int BCW = $clog2(VALUE_BITS);

	state_t state_q, state_d;
	logic [15:0]     pre_q, pre_d;
	logic [1:0]      pre_cnt_q, pre_cnt_d;
	logic [BCW-1:0]  bit_cnt_q, bit_cnt_d;
	logic [DCW-1:0]  dig_cnt_q, dig_cnt_d;

	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic            out_last_q;
	logic            out_inv_q;
	logic            load_out;
	logic [7:0]      ch_d;
	logic            last_d;
	logic            inv_d;
	logic            slot_free;

	logic [VALUE_BITS-1:0] v;
	logic [VALUE_BITS-1:0] mag;
	logic [IN_RADIX_W-1:0] radix;
	logic                  zero;
	logic                  neg;
	logic                  bad;
	logic                  is_hex;

	du_cmd_t     du_cmd;
	logic [3:0]  top_digit;

	assign v = s_tdata[VALUE_BITS-1:0];
	assign radix = s_tdata[IN_RADIX_LSB +: IN_RADIX_W];
	assign zero = (v == '0);
	assign is_hex = (radix == RADIX_HEX);
	assign bad = !zero && (radix != RADIX_DEC) && !is_hex;
	assign neg = (radix == RADIX_DEC) && s_tdata[IN_SIGNED_BIT] && v[VALUE_BITS-1];
	assign mag = neg ? (~v + VALUE_BITS'(1)) : v;

	assign slot_free = !out_valid_q || m_tready;

	i2t_digit_unit #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG(NDIG)
	) u_digit (
		.clk(clk),
		.cmd(du_cmd),
		.load_val(mag),
		.top_digit(top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pre_cnt_q <= '0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pre_cnt_q <= pre_cnt_d;
			bit_cnt_q <= bit_cnt_d;
			dig_cnt_q <= dig_cnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pre_q <= pre_d;
		if (load_out) begin
			out_char_q <= ch_d;
			out_last_q <= last_d;
			out_inv_q <= inv_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pre_d = pre_q;
		pre_cnt_d = pre_cnt_q;
		bit_cnt_d = bit_cnt_q;
		dig_cnt_d = dig_cnt_q;
		du_cmd = DU_HOLD;
		load_out = 1'b0;
		ch_d = CH_NONE;
		last_d = 1'b0;
		inv_d = 1'b0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					dig_cnt_d = DCW'(NDIG);
					bit_cnt_d = BCW'(VALUE_BITS - 1);
					if (bad) begin
						state_d = ST_BAD;
					end else if (is_hex) begin
						du_cmd = DU_LOAD_HEX;
						pre_d = {CH_ZERO, CH_X};
						pre_cnt_d = 2'd2;
						state_d = ST_NORM;
					end else begin
						du_cmd = DU_LOAD_DEC;
						pre_d = {CH_MINUS, CH_NONE};
						pre_cnt_d = neg ? 2'd1 : 2'd0;
						state_d = ST_CONV;
					end
				end
			end
			ST_CONV: begin
				du_cmd = DU_DABBLE;
				bit_cnt_d = bit_cnt_q - BCW'(1);
				if (bit_cnt_q == '0) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				// Drop leading zero digits but keep at least one.
				if (top_digit == 4'h0 && dig_cnt_q > DCW'(1)) begin
					du_cmd = DU_SHIFT;
					dig_cnt_d = dig_cnt_q - DCW'(1);
				end else if (pre_cnt_q != 2'd0) begin
					state_d = ST_PREFIX;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_PREFIX: begin
				if (slot_free) begin
					load_out = 1'b1;
					ch_d = pre_q[15:8];
					pre_d = {pre_q[7:0], CH_NONE};
					pre_cnt_d = pre_cnt_q - 2'd1;
					if (pre_cnt_q == 2'd1) begin
						state_d = ST_DIGIT;
					end
				end
			end
			ST_DIGIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					ch_d = digit_char(top_digit);
					last_d = (dig_cnt_q == DCW'(1));
					du_cmd = DU_SHIFT;
					dig_cnt_d = dig_cnt_q - DCW'(1);
					if (dig_cnt_q == DCW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_BAD: begin
				if (slot_free) begin
					load_out = 1'b1;
					ch_d = CH_NONE;
					last_d = 1'b1;
					inv_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_char_q;
	assign m_tlast = out_last_q;
	assign m_tuser = out_inv_q;

	`I2T_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready high right after an accepted item")
	`I2T_ASSERT_SAME(a_invalid_is_last, m_tvalid && m_tuser, m_tlast && (m_tdata == CH_NONE), "invalid transfer is not a lone zero character")
	`I2T_ASSERT_SAME(a_digits_left, state_q == ST_NORM || state_q == ST_DIGIT, dig_cnt_q != '0, "digit count ran out before the last character")
	`I2T_ASSERT_SAME(a_prefix_left, state_q == ST_PREFIX, pre_cnt_q != 2'd0, "prefix state entered with no prefix character")

endmodule

// ===== rtl/core/i2t_digit_unit.sv =====
// Shared digit register: shift-and-add-3 binary to BCD, hex load and digit shift-out.
module i2t_digit_unit
	import i2t_pkg::*;
#(
	parameter int VALUE_BITS = I2T_VALUE_BITS_DEF,
	parameter int NDIG = (I2T_VALUE_BITS_DEF * 30103) / 100000 + 1
) (
	input  logic                  clk,
	input  du_cmd_t               cmd,
	input  logic [VALUE_BITS-1:0] load_val,
	output logic [3:0]            top_digit
);

	localparam int DW = NDIG * 4;

	logic [VALUE_BITS-1:0] mag_q;
	logic [DW-1:0]         digit_q;
	logic [DW-1:0]         adj;

	// Each BCD digit of 5 or more gets 3 added before the next doubling.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (digit_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = digit_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = digit_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			DU_HOLD: begin
			end
			DU_LOAD_DEC: begin
				mag_q <= load_val;
				digit_q <= '0;
			end
			DU_LOAD_HEX: begin
				digit_q <= DW'(load_val);
			end
			DU_DABBLE: begin
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
				digit_q <= {adj[DW-2:0], mag_q[VALUE_BITS-1]};
			end
			DU_SHIFT: begin
				digit_q <= {digit_q[DW-5:0], 4'h0};
			end
			default: begin
			end
		endcase
	end

	assign top_digit = digit_q[DW-1 -: 4];

endmodule
